[hdl/vdvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdvs_pkg
// Shared types and constants of the vortex direct velocity sum unit.
// ----------------------------------------------------------------------------
package vdvs_pkg;

    localparam int COORD_BITS     = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int DIFF_BITS      = 33;
    localparam int PROD_BITS      = 64;
    localparam int DSQ_BITS       = 65;
    localparam int QUO_BITS       = 48;
    localparam int QS_BITS        = 49;
    localparam int DIV_CNT_BITS   = 6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_X    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_Y    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DIST_SQ = 2'd2;

    localparam logic [COORD_BITS-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_BITS-1:0] VEL_MIN = 32'h8000_0000;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_MAG      = 11'b000_0000_0010,
        ST_SQ_X     = 11'b000_0000_0100,
        ST_SQ_Y     = 11'b000_0000_1000,
        ST_SUM      = 11'b000_0001_0000,
        ST_CHECK    = 11'b000_0010_0000,
        ST_TERM     = 11'b000_0100_0000,
        ST_DIV_LOAD = 11'b000_1000_0000,
        ST_DIV      = 11'b001_0000_0000,
        ST_SIGN     = 11'b010_0000_0000,
        ST_ACC      = 11'b100_0000_0000
    } state_t;

endpackage

[hdl/vdvs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdvs_if
// Valid/ready channels of the vortex direct velocity sum unit.
// ----------------------------------------------------------------------------
interface vdvs_particle_if import vdvs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] source_x;
    logic [COORD_BITS-1:0] source_y;
    logic [COORD_BITS-1:0] strength;
    logic                  last_source;

    modport source (output valid, source_x, source_y, strength, last_source, input ready);
    modport sink   (input valid, source_x, source_y, strength, last_source, output ready);
endinterface

interface vdvs_result_if import vdvs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] vel_u;
    logic [COORD_BITS-1:0] vel_v;
    logic                  saturated;

    modport source (output valid, vel_u, vel_v, saturated, input ready);
    modport sink   (input valid, vel_u, vel_v, saturated, output ready);
endinterface

[hdl/vortex_direct_velocity_sum_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vortex_direct_velocity_sum_unit
// Direct 2-D Biot-Savart velocity sum of source particles at one target point.
// ----------------------------------------------------------------------------
// One particle transaction at a time. A particle within the minimum distance
// ends after difference, magnitude and distance squared; otherwise two terms
// follow, each a multiply, a 48-step radix-2 divide (one 67-bit subtract per
// cycle), sign and accumulate. Squares and term products share one 32x32
// multiplier. The particle marked last leaves its result in an output register
// and clears the sums; the next particle is taken while that result waits, and
// a further last particle waits until the pending result is taken.
// Configuration is to be written only while idle; the block does not enforce it.
module vortex_direct_velocity_sum_unit import vdvs_pkg::*;
#(
    parameter int ACC_BITS = 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    vdvs_particle_if.sink             particle,
    vdvs_result_if.source             result,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int EXT_BITS = ((ACC_BITS > QS_BITS) ? ACC_BITS : QS_BITS) + 1;
    localparam logic signed [EXT_BITS-1:0] ACC_MAX =
        {{(EXT_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [EXT_BITS-1:0] ACC_MIN =
        {{(EXT_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};

    state_t state_reg, state_next;

    logic [COORD_BITS-1:0]   target_x_reg, target_y_reg, min_dist_sq_reg;
    logic [ACC_BITS-1:0]     sum_u_reg, sum_v_reg;

    logic [DIFF_BITS-1:0]    dx_reg, dy_reg;
    logic [COORD_BITS-1:0]   w_reg;
    logic                    last_reg;
    logic [COORD_BITS-1:0]   ax_reg, ay_reg, aw_reg;
    logic                    term_reg;
    logic [PROD_BITS-1:0]    prod_reg;
    logic [DSQ_BITS-1:0]     dsq_reg;
    logic [DSQ_BITS-1:0]     rem_reg;
    logic [QUO_BITS-1:0]     quo_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [QS_BITS-1:0]      qs_reg;

    logic                    out_valid_reg;
    logic [COORD_BITS-1:0]   vel_u_reg, vel_v_reg;
    logic                    saturated_reg;

    logic                    accept;
    logic [DIFF_BITS-1:0]    dx_abs, dy_abs, w_abs;
    logic [COORD_BITS-1:0]   mul_a, mul_b;
    logic [PROD_BITS-1:0]    mul_p;
    logic [DSQ_BITS:0]       div_shift;
    logic [DSQ_BITS+1:0]     div_diff;
    logic                    div_borrow;
    logic                    far;
    logic                    term_neg;
    logic [ACC_BITS-1:0]     sum_sel;
    logic signed [EXT_BITS-1:0] acc_total;
    logic [ACC_BITS-1:0]     acc_sat;
    logic [ACC_BITS-1:0]     sum_v_fin;
    logic                    emit_ok;
    logic                    clip_u, clip_v;
    logic [COORD_BITS-1:0]   sat_u, sat_v;

    assign accept         = particle.valid && particle.ready;
    assign particle.ready = (state_reg == ST_IDLE);

    assign result.valid     = out_valid_reg;
    assign result.vel_u     = vel_u_reg;
    assign result.vel_v     = vel_v_reg;
    assign result.saturated = saturated_reg;

    assign dx_abs = dx_reg[DIFF_BITS-1] ? (DIFF_BITS'(0) - dx_reg) : dx_reg;
    assign dy_abs = dy_reg[DIFF_BITS-1] ? (DIFF_BITS'(0) - dy_reg) : dy_reg;
    assign w_abs  = w_reg[COORD_BITS-1] ? (DIFF_BITS'(0) - {1'b1, w_reg}) : {1'b0, w_reg};

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_X:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            ST_SQ_Y:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_TERM:
            begin
                mul_a = term_reg ? ax_reg : ay_reg;
                mul_b = aw_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Restoring divide step
    assign div_shift  = {rem_reg, quo_reg[QUO_BITS-1]};
    assign div_diff   = {1'b0, div_shift} - {2'b00, dsq_reg};
    assign div_borrow = div_diff[DSQ_BITS+1];

    assign far = dsq_reg[DSQ_BITS-1] ||
                 (dsq_reg[PROD_BITS-1:0] > {{(PROD_BITS-COORD_BITS){1'b0}}, min_dist_sq_reg});

    // u term carries an extra negation
    assign term_neg = (term_reg ? dx_reg[DIFF_BITS-1] : dy_reg[DIFF_BITS-1])
                      ^ w_reg[COORD_BITS-1] ^ ~term_reg;

    assign sum_sel   = term_reg ? sum_v_reg : sum_u_reg;
    assign acc_total = $signed({{(EXT_BITS-ACC_BITS){sum_sel[ACC_BITS-1]}}, sum_sel})
                     + $signed({{(EXT_BITS-QS_BITS){qs_reg[QS_BITS-1]}}, qs_reg});

    always_comb
    begin
        if (acc_total > ACC_MAX)
            acc_sat = ACC_MAX[ACC_BITS-1:0];
        else if (acc_total < ACC_MIN)
            acc_sat = ACC_MIN[ACC_BITS-1:0];
        else
            acc_sat = acc_total[ACC_BITS-1:0];
    end

    // v sum including the term being accumulated this cycle
    assign sum_v_fin = ((state_reg == ST_ACC) && term_reg) ? acc_sat : sum_v_reg;

    // Output clip to 32 bits
    assign clip_u = (sum_u_reg[ACC_BITS-1:COORD_BITS-1] != {(ACC_BITS-COORD_BITS+1){1'b0}}) &&
                    (sum_u_reg[ACC_BITS-1:COORD_BITS-1] != {(ACC_BITS-COORD_BITS+1){1'b1}});
    assign clip_v = (sum_v_fin[ACC_BITS-1:COORD_BITS-1] != {(ACC_BITS-COORD_BITS+1){1'b0}}) &&
                    (sum_v_fin[ACC_BITS-1:COORD_BITS-1] != {(ACC_BITS-COORD_BITS+1){1'b1}});
    assign sat_u  = clip_u ? (sum_u_reg[ACC_BITS-1] ? VEL_MIN : VEL_MAX)
                           : sum_u_reg[COORD_BITS-1:0];
    assign sat_v  = clip_v ? (sum_v_fin[ACC_BITS-1] ? VEL_MIN : VEL_MAX)
                           : sum_v_fin[COORD_BITS-1:0];

    // Result handoff: a pending result must be taken first
    assign emit_ok = !out_valid_reg || result.ready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MAG;
            end
            ST_MAG:      state_next = ST_SQ_X;
            ST_SQ_X:     state_next = ST_SQ_Y;
            ST_SQ_Y:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (far)
                    state_next = ST_TERM;
                else if (!last_reg || emit_ok)
                    state_next = ST_IDLE;
            end
            ST_TERM:     state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_SIGN;
            end
            ST_SIGN:     state_next = ST_ACC;
            ST_ACC:
            begin
                if (!term_reg)
                    state_next = ST_TERM;
                else if (!last_reg || emit_ok)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    logic finish;
    assign finish = ((state_reg == ST_CHECK) && !far) ||
                    ((state_reg == ST_ACC) && term_reg);

    // Control, configuration and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            min_dist_sq_reg <= 32'd1;
            sum_u_reg       <= '0;
            sum_v_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_TARGET_X:    target_x_reg    <= cfg_wdata;
                    CFG_TARGET_Y:    target_y_reg    <= cfg_wdata;
                    CFG_MIN_DIST_SQ: min_dist_sq_reg <= cfg_wdata;
                    default:         ;
                endcase
            end

            if (finish && last_reg && emit_ok && (state_next == ST_IDLE))
            begin
                out_valid_reg <= 1'b1;
                sum_u_reg     <= '0;
                sum_v_reg     <= '0;
            end
            else
            begin
                if (result.ready)
                    out_valid_reg <= 1'b0;

                if ((state_reg == ST_ACC) && !(term_reg && last_reg && !emit_ok))
                begin
                    if (term_reg)
                        sum_v_reg <= acc_sat;
                    else
                        sum_u_reg <= acc_sat;
                end
            end
        end
    end

    // Result register load
    always_ff @(posedge clk)
    begin
        if (finish && last_reg && emit_ok && (state_next == ST_IDLE))
        begin
            vel_u_reg     <= sat_u;
            vel_v_reg     <= sat_v;
            saturated_reg <= clip_u || clip_v;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dx_reg   <= {target_x_reg[COORD_BITS-1], target_x_reg}
                              - {particle.source_x[COORD_BITS-1], particle.source_x};
                    dy_reg   <= {target_y_reg[COORD_BITS-1], target_y_reg}
                              - {particle.source_y[COORD_BITS-1], particle.source_y};
                    w_reg    <= particle.strength;
                    last_reg <= particle.last_source;
                    term_reg <= 1'b0;
                end
            end
            ST_MAG:
            begin
                ax_reg <= dx_abs[COORD_BITS-1:0];
                ay_reg <= dy_abs[COORD_BITS-1:0];
                aw_reg <= w_abs[COORD_BITS-1:0];
            end
            ST_SQ_X:
            begin
                prod_reg <= mul_p;
            end
            ST_SQ_Y:
            begin
                prod_reg <= mul_p;
                dsq_reg  <= {1'b0, prod_reg};
            end
            ST_SUM:
            begin
                dsq_reg <= dsq_reg + {1'b0, prod_reg};
            end
            ST_TERM:
            begin
                prod_reg <= mul_p;
            end
            ST_DIV_LOAD:
            begin
                rem_reg <= {{(DSQ_BITS-31){1'b0}}, prod_reg[62:32]};
                quo_reg <= {prod_reg[31:0], 16'h0000};
                cnt_reg <= DIV_CNT_BITS'(QUO_BITS - 1);
            end
            ST_DIV:
            begin
                rem_reg <= div_borrow ? div_shift[DSQ_BITS-1:0] : div_diff[DSQ_BITS-1:0];
                quo_reg <= {quo_reg[QUO_BITS-2:0], ~div_borrow};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_SIGN:
            begin
                qs_reg <= term_neg ? (QS_BITS'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};
            end
            ST_ACC:
            begin
                if (!term_reg)
                    term_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
